@@ design/bsr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bsr_pkg;

    // Field widths
    localparam int OPCODE_W = 2;
    localparam int MEAS_W   = 16;
    localparam int SUM_W    = 24;
    localparam int LEVEL_W  = 12;
    localparam int MODE_W   = 2;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int PHASE_W  = 4;
    localparam int DIR_W    = 3;

    // Parameter defaults
    localparam int unsigned SUM_COUNT_DEF         = 16;
    localparam int unsigned DISCHARGE_FLOOR_DEF   = 0;
    localparam int unsigned DISCHARGE_CEILING_DEF = 4095;

    // Drive and tick limits
    localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 12'd4095;
    localparam logic [PHASE_W-1:0] PHASE_LAST = 4'd9;
    localparam logic [PHASE_W-1:0] PHASE_HALF = 4'd5;
    localparam logic [PHASE_W-1:0] PHASE_START = 4'd1;

    // Direction bit positions
    localparam int DIR_VOLT = 0;
    localparam int DIR_CHG  = 1;
    localparam int DIR_DIS  = 2;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK  = 2'd0,
        OP_CLEAR = 2'd1,
        OP_START = 2'd2
    } bsr_op_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_CHARGE     = 2'd0,
        MODE_DISCHARGE  = 2'd1,
        MODE_DIRECT_CHG = 2'd2,
        MODE_DIRECT_DIS = 2'd3
    } bsr_mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE        = 3'd0,
        REG_CHG_VOLT    = 3'd1,
        REG_CHG_CUR     = 3'd2,
        REG_DIS_SET     = 3'd3,
        REG_DIRECT_CUR  = 3'd4,
        REG_DIRECT_VOLT = 3'd5,
        REG_DIRECT_DIS  = 3'd6
    } bsr_reg_idx_t;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [MEAS_W-1:0]   chg_current;
        logic [MEAS_W-1:0]   bat_volt;
        logic [MEAS_W-1:0]   dis_current;
        logic [SUM_W-1:0]    chg_current_sum;
        logic [SUM_W-1:0]    bat_volt_sum;
        logic [SUM_W-1:0]    dis_current_sum;
    } bsr_in_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] charge_drive;
        logic [LEVEL_W-1:0] discharge_drive;
        logic               regulation_ok;
    } bsr_out_t;

    typedef struct packed {
        bsr_mode_t          mode;
        logic [MEAS_W-1:0]  charge_voltage_limit;
        logic [MEAS_W-1:0]  chg_current_limit;
        logic [MEAS_W-1:0]  dis_current_setpoint;
        logic [MEAS_W-1:0]  direct_current_target;
        logic [MEAS_W-1:0]  direct_voltage_target;
        logic [MEAS_W-1:0]  direct_discharge_target;
    } bsr_cfg_t;

endpackage

`default_nettype wire

@@ design/bsr_config.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsr_config
    import bsr_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic                 clear_targets,
    output bsr_cfg_t                  cfg
);

    bsr_cfg_t cfg_reg;
    bsr_cfg_t cfg_next;

    // Decode writes; a clear request zeroes the direct targets
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE:        cfg_next.mode = bsr_mode_t'(cfg_data[MODE_W-1:0]);
                REG_CHG_VOLT:    cfg_next.charge_voltage_limit = cfg_data;
                REG_CHG_CUR:     cfg_next.chg_current_limit = cfg_data;
                REG_DIS_SET:     cfg_next.dis_current_setpoint = cfg_data;
                REG_DIRECT_CUR:  cfg_next.direct_current_target = cfg_data;
                REG_DIRECT_VOLT: cfg_next.direct_voltage_target = cfg_data;
                REG_DIRECT_DIS:  cfg_next.direct_discharge_target = cfg_data;
                default: ;
            endcase
        end
        if (clear_targets) begin
            cfg_next.direct_current_target   = '0;
            cfg_next.direct_voltage_target   = '0;
            cfg_next.direct_discharge_target = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '{mode: MODE_CHARGE, default: '0};
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ design/bsr_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bsr_core
    import bsr_pkg::*;
#(
    parameter int unsigned SUM_COUNT         = SUM_COUNT_DEF,
    parameter int unsigned DISCHARGE_FLOOR   = DISCHARGE_FLOOR_DEF,
    parameter int unsigned DISCHARGE_CEILING = DISCHARGE_CEILING_DEF
) (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     fire,
    input  wire bsr_in_t  item,
    input  wire bsr_cfg_t cfg,
    output logic          clear_targets,
    output bsr_out_t      result
);

    localparam int PROD_W = MEAS_W + $clog2(SUM_COUNT + 1);
    localparam int CMP_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;
    localparam logic [LEVEL_W-1:0] DIS_FLOOR = LEVEL_W'(DISCHARGE_FLOOR);
    localparam logic [LEVEL_W-1:0] DIS_CEIL  = LEVEL_W'(DISCHARGE_CEILING);
    localparam logic [CMP_W-1:0]   N_SUM     = CMP_W'(SUM_COUNT);

    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [DIR_W-1:0]   dir_reg, dir_next;
    logic [LEVEL_W-1:0] chg_reg, chg_next;
    logic [LEVEL_W-1:0] dis_reg, dis_next;
    logic               ok_reg, ok_next;

    logic [MEAS_W-1:0] ic, vb, id;
    logic [CMP_W-1:0]  sc, sv, sd, tc, tv, td;
    logic              act5, act2, act10;

    assign ic = item.chg_current;
    assign vb = item.bat_volt;
    assign id = item.dis_current;
    assign sc = CMP_W'(item.chg_current_sum);
    assign sv = CMP_W'(item.bat_volt_sum);
    assign sd = CMP_W'(item.dis_current_sum);

    // Scale per-sample targets to the sum domain
    assign tc = CMP_W'(cfg.direct_current_target) * N_SUM;
    assign tv = CMP_W'(cfg.direct_voltage_target) * N_SUM;
    assign td = CMP_W'(cfg.direct_discharge_target) * N_SUM;

    // Decimation phases of the mod-10 tick counter
    assign act10 = (phase_reg == '0);
    assign act5  = act10 || (phase_reg == PHASE_HALF);
    assign act2  = !phase_reg[0];

    // Compute the state after one request
    always_comb begin
        phase_next    = phase_reg;
        dir_next      = dir_reg;
        chg_next      = chg_reg;
        dis_next      = dis_reg;
        ok_next       = ok_reg;
        clear_targets = 1'b0;
        unique case (item.opcode)
            OP_TICK: begin
                phase_next = (phase_reg == PHASE_LAST) ? '0 : phase_reg + 1'b1;
                unique case (cfg.mode)
                    MODE_CHARGE: begin
                        ok_next = 1'b0;
                        if (act5) begin
                            // track charge current crossing
                            if (ic > cfg.chg_current_limit) begin
                                if (dir_reg[DIR_CHG]) begin
                                    ok_next = 1'b1;
                                    dir_next[DIR_CHG] = 1'b0;
                                end
                            end else if (ic < cfg.chg_current_limit) begin
                                if (!dir_reg[DIR_CHG]) begin
                                    ok_next = 1'b1;
                                    dir_next[DIR_CHG] = 1'b1;
                                end
                            end else begin
                                ok_next = 1'b1;
                            end
                            // track voltage crossing
                            if (vb > cfg.charge_voltage_limit) begin
                                if (dir_reg[DIR_VOLT]) begin
                                    ok_next = 1'b1;
                                    dir_next[DIR_VOLT] = 1'b0;
                                end
                            end else if (vb < cfg.charge_voltage_limit) begin
                                if (!dir_reg[DIR_VOLT]) begin
                                    ok_next = 1'b1;
                                    dir_next[DIR_VOLT] = 1'b1;
                                end
                            end else begin
                                ok_next = 1'b1;
                            end
                            // step the charge drive
                            if (ic < cfg.chg_current_limit &&
                                vb < cfg.charge_voltage_limit) begin
                                if (chg_reg != LEVEL_MAX) chg_next = chg_reg + 1'b1;
                            end else if (ic > cfg.chg_current_limit ||
                                         vb > cfg.charge_voltage_limit) begin
                                if (chg_reg != '0) chg_next = chg_reg - 1'b1;
                            end else begin
                                ok_next = 1'b1;
                            end
                        end
                    end
                    MODE_DISCHARGE: begin
                        ok_next = 1'b0;
                        if (act2) begin
                            if (id > cfg.dis_current_setpoint) begin
                                if (dir_reg[DIR_DIS]) begin
                                    dir_next[DIR_DIS] = 1'b0;
                                    ok_next = 1'b1;
                                end
                                if (dis_reg > DIS_FLOOR) dis_next = dis_reg - 1'b1;
                            end else if (id < cfg.dis_current_setpoint) begin
                                if (!dir_reg[DIR_DIS]) begin
                                    dir_next[DIR_DIS] = 1'b1;
                                    ok_next = 1'b1;
                                end
                                if (dis_reg < DIS_CEIL) dis_next = dis_reg + 1'b1;
                            end else begin
                                ok_next = 1'b1;
                            end
                        end
                    end
                    MODE_DIRECT_CHG: begin
                        if (act10) begin
                            if (sc > tc || sv > tv) begin
                                if (chg_reg != '0) chg_next = chg_reg - 1'b1;
                            end else if (sc < tc && sv < tv) begin
                                if (chg_reg != LEVEL_MAX) chg_next = chg_reg + 1'b1;
                            end
                        end
                    end
                    MODE_DIRECT_DIS: begin
                        if (act5) begin
                            if (sd > td) begin
                                if (dis_reg > DIS_FLOOR) dis_next = dis_reg - 1'b1;
                            end else if (sd < td) begin
                                if (dis_reg < DIS_CEIL) dis_next = dis_reg + 1'b1;
                            end
                        end
                    end
                endcase
            end
            OP_CLEAR: begin
                dir_next      = '0;
                ok_next       = 1'b0;
                chg_next      = '0;
                dis_next      = '0;
                clear_targets = fire;
            end
            OP_START: begin
                phase_next         = PHASE_START;
                ok_next            = 1'b0;
                dir_next[DIR_VOLT] = vb < cfg.charge_voltage_limit;
                dir_next[DIR_CHG]  = ic < cfg.chg_current_limit;
                dir_next[DIR_DIS]  = id < cfg.dis_current_setpoint;
            end
            default: ;
        endcase
    end

    // Commit state once per accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= '0;
            dir_reg   <= '0;
            chg_reg   <= '0;
            dis_reg   <= '0;
            ok_reg    <= 1'b0;
        end else if (fire) begin
            phase_reg <= phase_next;
            dir_reg   <= dir_next;
            chg_reg   <= chg_next;
            dis_reg   <= dis_next;
            ok_reg    <= ok_next;
        end
    end

    assign result.charge_drive    = chg_next;
    assign result.discharge_drive = dis_next;
    assign result.regulation_ok   = ok_next;

endmodule

`default_nettype wire

@@ design/battery_step_regulator.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Battery step regulator: every request on s_ yields exactly one result on m_,
// in order. A request is captured in an input register, evaluated against the
// regulator state and written to the result register once that register is free or being
// drained, waiting in the input register until then; one request is taken every
// cycle while m_ready keeps the result register draining. Configuration
// writes take effect at the edge where cfg_wr_en is high and must be made with no
// request in flight. A clear request also zeroes the three direct-mode targets.
module battery_step_regulator
    import bsr_pkg::*;
#(
    parameter int unsigned SUM_COUNT         = SUM_COUNT_DEF,
    parameter int unsigned DISCHARGE_FLOOR   = DISCHARGE_FLOOR_DEF,
    parameter int unsigned DISCHARGE_CEILING = DISCHARGE_CEILING_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire bsr_in_t              s_data,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output bsr_out_t                  m_data,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    logic     in_valid_reg;
    bsr_in_t  in_item_reg;
    logic     out_valid_reg;
    bsr_out_t out_data_reg;
    logic     out_open;
    logic     fire;
    logic     clear_targets;
    bsr_cfg_t cfg;
    bsr_out_t result;

    // Advance when the result register is free or being drained
    assign out_open = !out_valid_reg || m_ready;
    assign fire     = in_valid_reg && out_open;
    assign s_ready  = !in_valid_reg || out_open;

    bsr_config u_config (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .clear_targets (clear_targets),
        .cfg           (cfg)
    );

    bsr_core #(
        .SUM_COUNT         (SUM_COUNT),
        .DISCHARGE_FLOOR   (DISCHARGE_FLOOR),
        .DISCHARGE_CEILING (DISCHARGE_CEILING)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .fire          (fire),
        .item          (in_item_reg),
        .cfg           (cfg),
        .clear_targets (clear_targets),
        .result        (result)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_open) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_data_reg <= result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

`default_nettype wire

@@ verif/battery_step_regulator_tb.sv @@
`timescale 1ns / 1ps

module battery_step_regulator_tb;
    import bsr_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;
    localparam int unsigned MEAS_TOP = 65535;
    localparam int unsigned SUM_TOP  = 24'hFFFFFF;
    localparam int STALL_PCT = 13;

    logic     aclk      = 1'b0;
    logic     aresetn   = 1'b0;
    logic     s_valid   = 1'b0;
    logic     s_ready;
    bsr_in_t  s_data    = '0;
    logic     m_valid;
    logic     m_ready   = 1'b0;
    bsr_out_t m_data;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;

    // Regulator image: configuration and state
    bsr_mode_t          cfg_mode     = MODE_CHARGE;
    logic [MEAS_W-1:0]  volt_limit   = '0;
    logic [MEAS_W-1:0]  cur_limit    = '0;
    logic [MEAS_W-1:0]  dis_setpoint = '0;
    logic [MEAS_W-1:0]  direct_cur   = '0;
    logic [MEAS_W-1:0]  direct_volt  = '0;
    logic [MEAS_W-1:0]  direct_dis   = '0;
    logic [PHASE_W-1:0] phase_count  = '0;
    logic [DIR_W-1:0]   cross_bits   = '0;
    logic [LEVEL_W-1:0] chg_level    = '0;
    logic [LEVEL_W-1:0] dis_level    = '0;
    logic               reg_ok       = 1'b0;

    bsr_out_t expected_drives[$];
    int       error_count = 0;
    logic     no_stall    = 1'b0;

    battery_step_regulator DUT (.*);

    initial begin
        forever #2 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("battery_step_regulator test failed");
        $finish;
    end

    // Remember which side of its setpoint a measurement sits on; flag a crossing
    function automatic void note_crossing(logic [MEAS_W-1:0] meas, logic [MEAS_W-1:0] setp,
                                          int bit_pos);
        if (meas > setp) begin
            if (cross_bits[bit_pos]) begin
                reg_ok = 1'b1;
                cross_bits[bit_pos] = 1'b0;
            end
        end else if (meas < setp) begin
            if (!cross_bits[bit_pos]) begin
                reg_ok = 1'b1;
                cross_bits[bit_pos] = 1'b1;
            end
        end else begin
            reg_ok = 1'b1;
        end
    endfunction

    function automatic void step_charge(logic up);
        if (up && chg_level != LEVEL_MAX)
            chg_level = chg_level + 1'b1;
        else if (!up && chg_level != 0)
            chg_level = chg_level - 1'b1;
    endfunction

    function automatic void step_discharge(logic up);
        if (up && dis_level < DISCHARGE_CEILING_DEF)
            dis_level = dis_level + 1'b1;
        else if (!up && dis_level > DISCHARGE_FLOOR_DEF)
            dis_level = dis_level - 1'b1;
    endfunction

    // Apply one request to the image and return the drive it reports
    function automatic bsr_out_t predict_drive(bsr_in_t req);
        bsr_out_t res;
        logic [31:0] goal_c, goal_v, goal_d;
        goal_c = direct_cur * SUM_COUNT_DEF;
        goal_v = direct_volt * SUM_COUNT_DEF;
        goal_d = direct_dis * SUM_COUNT_DEF;
        case (req.opcode)
            OP_TICK: begin
                case (cfg_mode)
                    MODE_CHARGE: begin
                        reg_ok = 1'b0;
                        if (phase_count % PHASE_HALF == 0) begin
                            note_crossing(req.chg_current, cur_limit, DIR_CHG);
                            note_crossing(req.bat_volt, volt_limit, DIR_VOLT);
                            if (req.chg_current < cur_limit && req.bat_volt < volt_limit)
                                step_charge(1'b1);
                            else if (req.chg_current > cur_limit
                                     || req.bat_volt > volt_limit)
                                step_charge(1'b0);
                            else
                                reg_ok = 1'b1;
                        end
                    end
                    MODE_DISCHARGE: begin
                        reg_ok = 1'b0;
                        if (!phase_count[0]) begin
                            note_crossing(req.dis_current, dis_setpoint, DIR_DIS);
                            if (req.dis_current > dis_setpoint)
                                step_discharge(1'b0);
                            else if (req.dis_current < dis_setpoint)
                                step_discharge(1'b1);
                        end
                    end
                    MODE_DIRECT_CHG: begin
                        if (phase_count == 0) begin
                            if (req.chg_current_sum > goal_c || req.bat_volt_sum > goal_v)
                                step_charge(1'b0);
                            else if (req.chg_current_sum < goal_c
                                     && req.bat_volt_sum < goal_v)
                                step_charge(1'b1);
                        end
                    end
                    default: begin
                        if (phase_count % PHASE_HALF == 0) begin
                            if (req.dis_current_sum > goal_d)
                                step_discharge(1'b0);
                            else if (req.dis_current_sum < goal_d)
                                step_discharge(1'b1);
                        end
                    end
                endcase
                phase_count = (phase_count == PHASE_LAST) ? '0 : phase_count + 1'b1;
            end
            OP_CLEAR: begin
                cross_bits  = '0;
                reg_ok      = 1'b0;
                direct_cur  = '0;
                direct_volt = '0;
                direct_dis  = '0;
                chg_level   = '0;
                dis_level   = '0;
            end
            OP_START: begin
                cross_bits = '0;
                cross_bits[DIR_VOLT] = req.bat_volt < volt_limit;
                cross_bits[DIR_CHG]  = req.chg_current < cur_limit;
                cross_bits[DIR_DIS]  = req.dis_current < dis_setpoint;
                phase_count = PHASE_START;
                reg_ok      = 1'b0;
            end
            default: ;
        endcase
        res.charge_drive    = chg_level;
        res.discharge_drive = dis_level;
        res.regulation_ok   = reg_ok;
        return res;
    endfunction

    function automatic bsr_in_t make_request(logic [OPCODE_W-1:0] op,
                                             logic [MEAS_W-1:0] ic, logic [MEAS_W-1:0] vb,
                                             logic [MEAS_W-1:0] id, logic [SUM_W-1:0] sc,
                                             logic [SUM_W-1:0] sv, logic [SUM_W-1:0] sd);
        bsr_in_t req;
        req.opcode          = op;
        req.chg_current     = ic;
        req.bat_volt        = vb;
        req.dis_current     = id;
        req.chg_current_sum = sc;
        req.bat_volt_sum    = sv;
        req.dis_current_sum = sd;
        return req;
    endfunction

    // Mostly a few steps around the center, sometimes anywhere in range
    function automatic int unsigned near_value(int unsigned center, int unsigned top);
        int v;
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(0, top);
        v = int'(center) + int'($urandom_range(0, 6)) - 3;
        if (v < 0)
            v = 0;
        if (v > int'(top))
            v = int'(top);
        return unsigned'(v);
    endfunction

    function automatic logic [MEAS_W-1:0] pick_setpoint();
        logic [MEAS_W-1:0] v;
        case ($urandom_range(0, 3))
            0: v = '0;
            1: v = '1;
            default: v = MEAS_W'($urandom_range(0, MEAS_TOP));
        endcase
        return v;
    endfunction

    // Drive one request, hold it until taken, then record its expected result
    task automatic send_request(input bsr_in_t req);
        @(negedge aclk);
        while (!no_stall && $urandom_range(0, 99) < STALL_PCT) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        expected_drives.push_back(predict_drive(req));
    endtask

    task automatic send_ticks(input int count, input logic [MEAS_W-1:0] ic,
                              input logic [MEAS_W-1:0] vb, input logic [MEAS_W-1:0] id,
                              input logic [SUM_W-1:0] sc, input logic [SUM_W-1:0] sv,
                              input logic [SUM_W-1:0] sd);
        repeat (count) send_request(make_request(OP_TICK, ic, vb, id, sc, sv, sd));
    endtask

    // Drop valid and hold until every result is back and the pipeline is empty
    task automatic wait_idle();
        @(negedge aclk);
        s_valid <= 1'b0;
        wait (expected_drives.size() == 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(input bsr_reg_idx_t idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_MODE:        cfg_mode     = bsr_mode_t'(val[MODE_W-1:0]);
            REG_CHG_VOLT:    volt_limit   = val;
            REG_CHG_CUR:     cur_limit    = val;
            REG_DIS_SET:     dis_setpoint = val;
            REG_DIRECT_CUR:  direct_cur   = val;
            REG_DIRECT_VOLT: direct_volt  = val;
            REG_DIRECT_DIS:  direct_dis   = val;
            default: ;
        endcase
    endtask

    task automatic set_config(input bsr_mode_t m, input logic [CFG_W-1:0] cv,
                              input logic [CFG_W-1:0] cc, input logic [CFG_W-1:0] ds,
                              input logic [CFG_W-1:0] dc, input logic [CFG_W-1:0] dv,
                              input logic [CFG_W-1:0] dd);
        wait_idle();
        write_reg(REG_MODE, CFG_W'(m));
        write_reg(REG_CHG_VOLT, cv);
        write_reg(REG_CHG_CUR, cc);
        write_reg(REG_DIS_SET, ds);
        write_reg(REG_DIRECT_CUR, dc);
        write_reg(REG_DIRECT_VOLT, dv);
        write_reg(REG_DIRECT_DIS, dd);
    endtask

    // Reset configuration: equal, maximum, unused opcode, clear
    task automatic test_reset_state();
        send_ticks(1, '0, '0, '0, '0, '0, '0);
        send_ticks(1, '1, '1, '1, '1, '1, '1);
        send_request(make_request(OP_UNUSED, '1, '1, '1, '1, '1, '1));
        send_request(make_request(OP_CLEAR, '1, '1, '1, '1, '1, '1));
    endtask

    // Both measurements below their limits: step up and flag the voltage crossing
    task automatic test_charge_rule();
        set_config(MODE_CHARGE, 16'd1000, 16'd500, 16'd300, '0, '0, '0);
        send_request(make_request(OP_START, 16'd400, 16'd1200, 16'd200, '0, '0, '0));
        send_ticks(5, 16'd400, 16'd900, 16'd200, '0, '0, '0);
    endtask

    task automatic test_discharge_rule();
        set_config(MODE_DISCHARGE, 16'd1000, 16'd500, 16'd300, '0, '0, '0);
        send_request(make_request(OP_START, '0, '0, '1, '0, '0, '0));
        send_ticks(3, '0, '0, '0, '0, '0, '0);
    endtask

    // Direct discharge one above target, then direct charge with a full voltage sum
    task automatic test_direct_rules();
        set_config(MODE_DIRECT_DIS, '0, '0, '0, 16'd50, 16'd60, 16'd100);
        send_request(make_request(OP_START, '0, '0, '0, '0, '0, '0));
        send_ticks(5, '0, '0, '0, '0, '0, 24'd1601);
        set_config(MODE_DIRECT_CHG, '0, '0, '0, 16'd50, 16'd60, 16'd100);
        send_ticks(5, '0, '0, '0, '0, '1, '0);
    endtask

    // Hold both drives at the floor while every measurement sits above its setpoint
    task automatic test_drive_saturation();
        set_config(MODE_DISCHARGE, '0, '0, '0, '0, '0, '0);
        send_request(make_request(OP_CLEAR, '0, '0, '0, '0, '0, '0));
        send_ticks(10, '1, '1, '1, '1, '1, '1);
        set_config(MODE_CHARGE, '0, '0, '0, '0, '0, '0);
        send_ticks(12, '1, '1, '1, '1, '1, '1);
        set_config(MODE_DIRECT_CHG, '0, '0, '0, '0, '0, '0);
        send_ticks(10, '1, '1, '1, '1, '1, '1);
    endtask

    // Phases of settings (all zero, all ones, then random); measurements cluster around the setpoints
    task automatic test_random_traffic();
        int p, n, roll;
        logic [OPCODE_W-1:0] op;
        bsr_mode_t m;
        logic [CFG_W-1:0] sp[6];
        for (p = 0; p < 7; p++) begin
            m = (p < 4) ? bsr_mode_t'(p) : bsr_mode_t'($urandom_range(0, 3));
            foreach (sp[k])
                sp[k] = (p == 0) ? '0 : (p == 1) ? '1 : pick_setpoint();
            set_config(m, sp[0], sp[1], sp[2], sp[3], sp[4], sp[5]);
            no_stall = (p == 3);
            send_request(make_request(OP_START,
                MEAS_W'(near_value(32'(cur_limit), MEAS_TOP)),
                MEAS_W'(near_value(32'(volt_limit), MEAS_TOP)),
                MEAS_W'(near_value(32'(dis_setpoint), MEAS_TOP)),
                SUM_W'($urandom), SUM_W'($urandom), SUM_W'($urandom)));
            for (n = 0; n < 140; n++) begin
                // hold off until the block has drained completely
                if (p == 2 && n == 70)
                    wait_idle();
                roll = $urandom_range(0, 99);
                if (roll < 4)
                    op = OP_CLEAR;
                else if (roll < 10)
                    op = OP_START;
                else if (roll < 12)
                    op = OP_UNUSED;
                else
                    op = OP_TICK;
                send_request(make_request(op,
                    MEAS_W'(near_value(32'(cur_limit), MEAS_TOP)),
                    MEAS_W'(near_value(32'(volt_limit), MEAS_TOP)),
                    MEAS_W'(near_value(32'(dis_setpoint), MEAS_TOP)),
                    SUM_W'(near_value(direct_cur * SUM_COUNT_DEF, SUM_TOP)),
                    SUM_W'(near_value(direct_volt * SUM_COUNT_DEF, SUM_TOP)),
                    SUM_W'(near_value(direct_dis * SUM_COUNT_DEF, SUM_TOP))));
            end
            no_stall = 1'b0;
        end
    endtask

    // Stall the result side at random
    always @(negedge aclk) begin
        m_ready <= no_stall || ($urandom_range(0, 99) >= STALL_PCT);
    end

    // Compare each result with the oldest expectation
    always @(posedge aclk) begin
        bsr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_drives.size() == 0) begin
                error_count++;
                $display("%0t: result with no request pending, expected none, got %h",
                         $time, m_data);
            end else begin
                want = expected_drives.pop_front();
                if (m_data.charge_drive !== want.charge_drive) begin
                    error_count++;
                    $display("%0t: charge_drive expected %0d, got %0d",
                             $time, want.charge_drive, m_data.charge_drive);
                end
                if (m_data.discharge_drive !== want.discharge_drive) begin
                    error_count++;
                    $display("%0t: discharge_drive expected %0d, got %0d",
                             $time, want.discharge_drive, m_data.discharge_drive);
                end
                if (m_data.regulation_ok !== want.regulation_ok) begin
                    error_count++;
                    $display("%0t: regulation_ok expected %0d, got %0d",
                             $time, want.regulation_ok, m_data.regulation_ok);
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_reset_state();
        test_charge_rule();
        test_discharge_rule();
        test_direct_rules();
        test_drive_saturation();
        test_random_traffic();
        wait_idle();
        repeat (10) @(posedge aclk);
        if (error_count == 0)
            $display("battery_step_regulator test passed");
        else
            $display("battery_step_regulator test failed");
        $finish;
    end

endmodule

@@ sim.f @@
design/bsr_pkg.sv
design/bsr_config.sv
design/bsr_core.sv
design/battery_step_regulator.sv
verif/battery_step_regulator_tb.sv
